FILE: design/u2c_pkg.sv
// ----------------------------------------------------------------------------
// u2c_pkg
// Shared types, constants and mapping functions for the UTF-8 to CP437
// transcoder.
// ----------------------------------------------------------------------------
package u2c_pkg;

    localparam int MAX_W        = 12;
    localparam logic [MAX_W-1:0] MAX_CHARS_RST = 12'd95;

    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int LIST_LEN     = 5;
    localparam int LIST_IDX_W   = $clog2(LIST_LEN + 1);

    localparam logic [15:0] ELLIPSIS_CP = 16'h2026;
    localparam logic [7:0]  CHAR_DOT    = 8'h2E;
    localparam logic [7:0]  CHAR_QMARK  = 8'h3F;
    localparam logic [7:0]  TERM_CHAR   = 8'h00;
    localparam logic [7:0]  CONT_MASK   = 8'hC0;
    localparam logic [7:0]  CONT_TAG    = 8'h80;

    localparam logic [1:0]  NEED_NONE   = 2'd0;
    localparam logic [1:0]  NEED_ONE    = 2'd1;
    localparam logic [1:0]  NEED_TWO    = 2'd2;
    localparam logic [1:0]  NEED_THREE  = 2'd3;

    typedef struct packed {
        logic [7:0] chr;
        logic       last;
    } t_entry;

    function automatic logic [7:0] map_cp(input logic [15:0] cp);
        logic [7:0] m;
        if (cp < 16'h0080) begin
            m = cp[7:0];
        end else begin
            unique case (cp)
                16'h00E4: m = 8'h84;
                16'h00F6: m = 8'h94;
                16'h00FC: m = 8'h81;
                16'h00C4: m = 8'h8E;
                16'h00D6: m = 8'h99;
                16'h00DC: m = 8'h9A;
                16'h00DF: m = 8'hE1;
                16'h00E0: m = 8'h85;
                16'h00E1: m = 8'hA0;
                16'h00E2: m = 8'h83;
                16'h00E8: m = 8'h8A;
                16'h00E9: m = 8'h82;
                16'h00EA: m = 8'h88;
                16'h00EB: m = 8'h89;
                16'h00EC: m = 8'h8D;
                16'h00ED: m = 8'hA1;
                16'h00EE: m = 8'h8C;
                16'h00EF: m = 8'h8B;
                16'h00F2: m = 8'h95;
                16'h00F3: m = 8'hA2;
                16'h00F4: m = 8'h93;
                16'h00F9: m = 8'h97;
                16'h00FA: m = 8'hA3;
                16'h00FB: m = 8'h96;
                16'h00E7: m = 8'h87;
                16'h00C7: m = 8'h80;
                16'h00F1: m = 8'hA4;
                16'h00D1: m = 8'hA5;
                16'h00E5: m = 8'h86;
                16'h00C5: m = 8'h8F;
                16'h00E6: m = 8'h91;
                16'h00C6: m = 8'h92;
                16'h00C9: m = 8'h90;
                16'h00A0: m = 8'h20;
                16'h00B0: m = 8'hF8;
                16'h00A7: m = 8'h15;
                16'h00B5: m = 8'hE6;
                16'h00B1: m = 8'hF1;
                16'h00F7: m = 8'hF6;
                16'h00AB: m = 8'hAE;
                16'h00BB: m = 8'hAF;
                16'h00BF: m = 8'hA8;
                16'h00A1: m = 8'hAD;
                16'h2022: m = 8'h07;
                16'h2018, 16'h2019, 16'h201A: m = 8'h27;
                16'h201C, 16'h201D, 16'h201E: m = 8'h22;
                16'h2013, 16'h2014, 16'h2212: m = 8'h2D;
                default: m = 8'h00;
            endcase
        end
        return m;
    endfunction

    // code point to a shown character, '?' when there is none
    function automatic logic [7:0] cp_char(input logic [15:0] cp);
        logic [7:0] m;
        m = map_cp(cp);
        return (m != 8'h00) ? m : CHAR_QMARK;
    endfunction

    // continuation bytes a lead byte asks for
    function automatic logic [1:0] lead_need(input logic [7:0] b);
        logic [1:0] n;
        priority if ((b & 8'hE0) == 8'hC0) n = NEED_ONE;
        else if ((b & 8'hF0) == 8'hE0) n = NEED_TWO;
        else if ((b & 8'hF8) == 8'hF0) n = NEED_THREE;
        else n = NEED_NONE;
        return n;
    endfunction

endpackage

FILE: design/u2c_front.sv
// ----------------------------------------------------------------------------
// u2c_front
// Decodes each input byte against the held sequence, builds the list of
// characters it yields and issues them one per cycle while the queue has room.
// ----------------------------------------------------------------------------
module u2c_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [7:0]        i_byte,
    input  logic              i_eos,
    output logic              o_push_valid,
    output u2c_pkg::t_entry   o_push_entry,
    input  logic              i_q_full
);
    import u2c_pkg::*;

    logic [7:0]            r_pend [3];
    logic [1:0]            r_pc;
    logic [1:0]            r_sl;
    logic [7:0]            r_list [LIST_LEN];
    logic [LIST_IDX_W-1:0] r_nchr;
    logic                  r_term;
    logic [LIST_IDX_W-1:0] r_idx;
    logic                  r_busy;

    logic [7:0]            n_pend [3];
    logic [1:0]            n_pc;
    logic [1:0]            n_sl;
    logic [7:0]            n_list [LIST_LEN];
    logic [LIST_IDX_W-1:0] n_nchr;
    logic                  n_term;
    logic [LIST_IDX_W-1:0] n_idx;
    logic                  n_busy;

    logic [LIST_IDX_W-1:0] total;
    logic                  push;
    logic                  last_push;
    logic                  accept;

    // build the character list of the byte on the input
    always_comb begin
        logic       start;
        logic       is_cont;
        logic [1:0] need;
        logic [15:0] cp;
        n_pend  = r_pend;
        n_pc    = r_pc;
        n_sl    = r_sl;
        n_nchr  = '0;
        start   = 1'b0;
        cp      = '0;
        need    = NEED_NONE;
        for (int i = 0; i < LIST_LEN; i++) n_list[i] = TERM_CHAR;
        n_term  = (i_byte == 8'h00) || i_eos;
        is_cont = (i_byte & CONT_MASK) == CONT_TAG;

        if (i_byte != 8'h00) begin
            if (r_pc == 2'd0) begin
                start = 1'b1;
            end else if (!is_cont) begin
                for (int i = 0; i < 3; i++) begin
                    if (2'(i) < r_pc) begin
                        n_list[n_nchr] = cp_char({8'h00, r_pend[i]});
                        n_nchr = n_nchr + LIST_IDX_W'(1);
                    end
                end
                n_pc  = 2'd0;
                n_sl  = NEED_NONE;
                start = 1'b1;
            end else if (r_pc < r_sl) begin
                if (r_pc == 2'd1) n_pend[1] = i_byte;
                else n_pend[2] = i_byte;
                n_pc = r_pc + 2'd1;
            end else begin
                if (r_sl == NEED_ONE)
                    cp = {5'd0, r_pend[0][4:0], i_byte[5:0]};
                else if (r_sl == NEED_TWO)
                    cp = {r_pend[0][3:0], r_pend[1][5:0], i_byte[5:0]};
                else
                    cp = 16'h0000;
                n_pc = 2'd0;
                n_sl = NEED_NONE;
                if (cp == ELLIPSIS_CP) begin
                    for (int i = 0; i < 3; i++) begin
                        n_list[n_nchr] = CHAR_DOT;
                        n_nchr = n_nchr + LIST_IDX_W'(1);
                    end
                end else begin
                    n_list[n_nchr] = cp_char(cp);
                    n_nchr = n_nchr + LIST_IDX_W'(1);
                end
            end

            if (start) begin
                need = lead_need(i_byte);
                if (i_byte[7] == 1'b0 || need == NEED_NONE) begin
                    n_list[n_nchr] = cp_char({8'h00, i_byte});
                    n_nchr = n_nchr + LIST_IDX_W'(1);
                end else begin
                    n_pend[0] = i_byte;
                    n_pc      = 2'd1;
                    n_sl      = need;
                end
            end
        end

        // end of string: replay what is held
        if (n_term) begin
            for (int i = 0; i < 3; i++) begin
                if (2'(i) < n_pc) begin
                    n_list[n_nchr] = cp_char({8'h00, n_pend[i]});
                    n_nchr = n_nchr + LIST_IDX_W'(1);
                end
            end
            n_pc = 2'd0;
            n_sl = NEED_NONE;
        end
    end

    assign total     = r_nchr + {{(LIST_IDX_W-1){1'b0}}, r_term};
    assign push      = r_busy && !i_q_full;
    assign last_push = push && (r_idx == total - LIST_IDX_W'(1));
    assign o_s_axis_tready = !r_busy || last_push;
    assign accept    = i_s_axis_tvalid && o_s_axis_tready;

    assign o_push_valid       = push;
    assign o_push_entry.chr   = (r_idx < r_nchr) ? r_list[r_idx] : TERM_CHAR;
    assign o_push_entry.last  = !(r_idx < r_nchr);

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        if (accept) begin
            n_busy = (n_nchr != '0) || n_term;
            n_idx  = '0;
        end else if (last_push) begin
            n_busy = 1'b0;
        end else if (push) begin
            n_idx  = r_idx + LIST_IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_pc   <= 2'd0;
            r_sl   <= NEED_NONE;
            r_term <= 1'b0;
            r_nchr <= '0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
            if (accept) begin
                r_pc   <= n_pc;
                r_sl   <= n_sl;
                r_term <= n_term;
                r_nchr <= n_nchr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend <= n_pend;
            r_list <= n_list;
        end
    end

    a_pc_within_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= r_sl)
        else $error("held byte count beyond sequence length");

    a_idx_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx < total))
        else $error("issue index past end of list");

endmodule

FILE: design/u2c_queue.sv
// ----------------------------------------------------------------------------
// u2c_queue
// Short FIFO of character entries between the decoder and the output stage.
// ----------------------------------------------------------------------------
module u2c_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  u2c_pkg::t_entry   i_push_entry,
    output logic              o_full,
    output logic              o_valid,
    output u2c_pkg::t_entry   o_pop_entry,
    input  logic              i_pop
);
    import u2c_pkg::*;

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;

    assign o_full      = r_count == QCNT_W'(QUEUE_DEPTH);
    assign o_valid     = r_count != '0;
    assign o_pop_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            if (i_pop)  r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            if (i_push && !i_pop)      r_count <= r_count + QCNT_W'(1);
            else if (!i_push && i_pop) r_count <= r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_push_entry;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("pop from empty queue");

endmodule

FILE: design/u2c_back.sv
// ----------------------------------------------------------------------------
// u2c_back
// Applies the character budget to queued entries and drives the output
// register; holds the max_chars register.
// ----------------------------------------------------------------------------
module u2c_back #(
    parameter int COUNT_BITS = 12
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [u2c_pkg::MAX_W-1:0] i_cfg_data,
    input  logic                      i_q_valid,
    input  u2c_pkg::t_entry           i_q_entry,
    output logic                      o_pop,
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    output logic [7:0]                o_m_axis_tdata,
    output logic                      o_m_axis_tlast
);
    import u2c_pkg::*;

    localparam int CMP_W = (COUNT_BITS > MAX_W) ? COUNT_BITS : MAX_W;

    logic [MAX_W-1:0]      r_max;
    logic [COUNT_BITS-1:0] r_count;
    logic                  r_done;
    logic                  r_valid;
    logic [7:0]            r_data;
    logic                  r_last;

    logic [COUNT_BITS-1:0] n_count;
    logic                  n_done;
    logic                  n_valid;
    logic [7:0]            n_data;
    logic                  n_last;

    logic                  can_load;
    logic                  full_now;
    logic                  full_next;
    logic [COUNT_BITS-1:0] cnt_inc;

    assign o_cfg_ready = 1'b1;
    assign can_load    = !r_valid || i_m_axis_tready;
    assign o_pop       = can_load && i_q_valid;
    assign cnt_inc     = r_count + COUNT_BITS'(1);
    assign full_now    = (CMP_W'(r_count) >= CMP_W'(r_max)) || (r_count == '1);
    assign full_next   = (CMP_W'(cnt_inc) >= CMP_W'(r_max)) || (cnt_inc == '1);

    always_comb begin
        n_count = r_count;
        n_done  = r_done;
        n_valid = r_valid;
        n_data  = r_data;
        n_last  = r_last;
        if (can_load) n_valid = 1'b0;
        if (o_pop) begin
            if (i_q_entry.last) begin
                n_valid = 1'b1;
                n_data  = TERM_CHAR;
                n_last  = 1'b1;
                n_count = '0;
                n_done  = 1'b0;
            end else if (r_done || full_now) begin
                n_done  = 1'b1;
            end else begin
                n_valid = 1'b1;
                n_data  = i_q_entry.chr;
                n_last  = 1'b0;
                n_count = cnt_inc;
                n_done  = full_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max   <= MAX_CHARS_RST;
            r_count <= '0;
            r_done  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_max <= i_cfg_data;
            r_count <= n_count;
            r_done  <= n_done;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_last <= n_last;
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = r_data;
    assign o_m_axis_tlast  = r_last;

    a_term_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_last) |-> (r_data == TERM_CHAR))
        else $error("terminator carries nonzero data");

    a_term_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_q_entry.last) |=> (r_count == '0 && !r_done))
        else $error("string state not cleared after terminator");

endmodule

FILE: design/utf8_to_cp437_transcoder.sv
// Path: the first CP437 byte of an input byte passes the decoder's list register,
// the queue and the output register before it is valid.
// Throughput: one input byte per cycle while each byte yields at most one result
// and the queue has room; a byte yielding more (replays, ellipsis, terminator) holds
// the input until all are issued, one queue entry per cycle while the queue has room.
// Reset: synchronous, active low; clears held bytes, counters, queue; max_chars = 95.
// ----------------------------------------------------------------------------
// utf8_to_cp437_transcoder
// UTF-8 byte stream in, CP437 byte stream out, with a per-string character
// budget and a zero terminator marked last.
// ----------------------------------------------------------------------------
module utf8_to_cp437_transcoder #(
    parameter int COUNT_BITS = 12
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [u2c_pkg::MAX_W-1:0] i_cfg_data,      // max_chars
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  logic [7:0]                i_s_axis_tdata,  // in_byte
    input  logic                      i_s_axis_tlast,  // end_of_string
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    output logic [7:0]                o_m_axis_tdata,  // out_char
    output logic                      o_m_axis_tlast   // last
);
    import u2c_pkg::*;

    logic   push_valid;
    t_entry push_entry;
    logic   q_full;
    logic   q_valid;
    t_entry q_entry;
    logic   pop;

    u2c_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_byte          (i_s_axis_tdata),
        .i_eos           (i_s_axis_tlast),
        .o_push_valid    (push_valid),
        .o_push_entry    (push_entry),
        .i_q_full        (q_full)
    );

    u2c_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push_valid),
        .i_push_entry (push_entry),
        .o_full       (q_full),
        .o_valid      (q_valid),
        .o_pop_entry  (q_entry),
        .i_pop        (pop)
    );

    u2c_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_q_valid       (q_valid),
        .i_q_entry       (q_entry),
        .o_pop           (pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule
